/* rtl/core/arhp_pkg.sv */
package arhp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_PAYLOAD,
        PH_PAD,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_END         = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_TRAILER = 3'd3,
        ST_TRUNC       = 3'd4
    } status_t;

    localparam int NAME_BYTES = 16;
    localparam int SIZE_W     = 34;
    localparam int FIELD_W    = 6;
    localparam int NCOUNT_W   = 5;
    localparam int DOFF_W     = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCOUNT_W    = 3;

    localparam logic [FIELD_W-1:0]  MAGIC_LAST      = 6'd7;
    localparam logic [FIELD_W-1:0]  HDR_NAME_END    = 6'd16;
    localparam logic [FIELD_W-1:0]  HDR_SIZE_FIRST  = 6'd48;
    localparam logic [FIELD_W-1:0]  HDR_TRAILER0    = 6'd58;
    localparam logic [FIELD_W-1:0]  HDR_TRAILER1    = 6'd59;
    localparam logic [NCOUNT_W-1:0] NAME_FULL       = 5'd16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_GRAVE = 8'h60;
    localparam logic [7:0] CH_LF    = 8'h0A;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h21;
            3'd1: b = 8'h3C;
            3'd2: b = 8'h61;
            3'd3: b = 8'h72;
            3'd4: b = 8'h63;
            3'd5: b = 8'h68;
            3'd6: b = 8'h3E;
            3'd7: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    typedef struct packed {
        status_t             status;
        logic [63:0]         name_low;
        logic [63:0]         name_high;
        logic [NCOUNT_W-1:0] name_length;
        logic [SIZE_W-1:0]   member_size;
        logic [DOFF_W-1:0]   data_offset;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

endpackage

/* rtl/core/arhp_parser.sv */
module arhp_parser #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output arhp_pkg::step_t     step
);

    arhp_pkg::phase_t                    phase_reg, phase_next, phase_mid;
    logic [arhp_pkg::FIELD_W-1:0]        field_reg, field_next, field_mid;
    logic [1:0][63:0]                    name_reg, name_next;
    logic [arhp_pkg::NCOUNT_W-1:0]       ncount_reg, ncount_next;
    logic                                name_ended_reg, name_ended_next;
    logic [arhp_pkg::SIZE_W-1:0]         size_reg, size_next;
    logic                                digits_ended_reg, digits_ended_next;
    logic                                trail_ok_reg, trail_ok_next;
    logic [arhp_pkg::SIZE_W-1:0]         remain_reg, remain_next;
    logic                                pad_reg, pad_next;
    logic [OFFSET_WIDTH-1:0]             offset_reg, offset_next, offset_inc;
    logic [OFFSET_WIDTH+31:0]            offset_ext;
    logic [arhp_pkg::DOFF_W-1:0]         data_offset;
    logic                                start_header;
    logic [arhp_pkg::SIZE_W-1:0]         remain_dec;

    logic                                magic_bad;
    logic                                trailer_step;
    logic                                trailer_good;
    logic                                step_hit;
    arhp_pkg::status_t                   step_status;
    logic                                end_hit;
    arhp_pkg::status_t                   end_status;
    arhp_pkg::result_t                   res_step, res_end;

    assign offset_inc = (&offset_reg) ? offset_reg : offset_reg + 1'b1;
    assign offset_ext = {32'd0, offset_inc};
    assign data_offset = (|offset_ext[OFFSET_WIDTH+31:32]) ? '1 : offset_ext[31:0];
    assign remain_dec = remain_reg - 1'b1;

    assign magic_bad    = (phase_reg == arhp_pkg::PH_MAGIC) &&
                          (in_byte != arhp_pkg::magic_byte(field_reg[2:0]));
    assign trailer_step = (phase_reg == arhp_pkg::PH_HEADER) &&
                          (field_reg >= arhp_pkg::HDR_TRAILER1);
    assign trailer_good = trail_ok_reg && (in_byte == arhp_pkg::CH_LF);

    always_comb begin
        phase_mid         = phase_reg;
        field_mid         = field_reg;
        name_next         = name_reg;
        ncount_next       = ncount_reg;
        name_ended_next   = name_ended_reg;
        size_next         = size_reg;
        digits_ended_next = digits_ended_reg;
        trail_ok_next     = trail_ok_reg;
        remain_next       = remain_reg;
        pad_next          = pad_reg;
        offset_next       = offset_inc;
        start_header      = 1'b0;

        unique case (phase_reg)
            arhp_pkg::PH_MAGIC: begin
                if (magic_bad) begin
                    phase_mid = arhp_pkg::PH_HALT;
                end else if (field_reg >= arhp_pkg::MAGIC_LAST) begin
                    start_header = 1'b1;
                end else begin
                    field_mid = field_reg + 1'b1;
                end
            end
            arhp_pkg::PH_HEADER: begin
                if (field_reg < arhp_pkg::HDR_NAME_END) begin
                    if (!name_ended_reg) begin
                        if (in_byte == arhp_pkg::CH_SLASH || in_byte == arhp_pkg::CH_SPACE ||
                            in_byte == arhp_pkg::CH_NUL) begin
                            name_ended_next = 1'b1;
                        end else if (ncount_reg < arhp_pkg::NAME_FULL) begin
                            name_next[ncount_reg[3]][{ncount_reg[2:0], 3'b000} +: 8] = in_byte;
                            ncount_next = ncount_reg + 1'b1;
                        end
                    end
                end else if (field_reg >= arhp_pkg::HDR_SIZE_FIRST &&
                             field_reg < arhp_pkg::HDR_TRAILER0) begin
                    if (!digits_ended_reg) begin
                        if (in_byte >= arhp_pkg::CH_ZERO && in_byte <= arhp_pkg::CH_NINE) begin
                            size_next = (size_reg << 3) + (size_reg << 1) +
                                        arhp_pkg::SIZE_W'(in_byte - arhp_pkg::CH_ZERO);
                        end else begin
                            digits_ended_next = 1'b1;
                        end
                    end
                end else if (field_reg == arhp_pkg::HDR_TRAILER0) begin
                    trail_ok_next = (in_byte == arhp_pkg::CH_GRAVE);
                end
                if (trailer_step) begin
                    if (trailer_good) begin
                        remain_next = size_reg;
                        pad_next    = size_reg[0];
                        if (size_reg != '0) begin
                            phase_mid = arhp_pkg::PH_PAYLOAD;
                            field_mid = '0;
                        end else begin
                            start_header = 1'b1;
                        end
                    end else begin
                        phase_mid = arhp_pkg::PH_HALT;
                    end
                end else begin
                    field_mid = field_reg + 1'b1;
                end
            end
            arhp_pkg::PH_PAYLOAD: begin
                remain_next = (remain_reg != '0) ? remain_dec : remain_reg;
                if (remain_reg <= arhp_pkg::SIZE_W'(1)) begin
                    if (pad_reg) begin
                        phase_mid = arhp_pkg::PH_PAD;
                        field_mid = '0;
                    end else begin
                        start_header = 1'b1;
                    end
                end
            end
            arhp_pkg::PH_PAD: begin
                pad_next     = 1'b0;
                start_header = 1'b1;
            end
            default: begin
                phase_mid = arhp_pkg::PH_HALT;
            end
        endcase

        if (start_header) begin
            phase_mid         = arhp_pkg::PH_HEADER;
            field_mid         = '0;
            name_next         = '0;
            ncount_next       = '0;
            name_ended_next   = 1'b0;
            size_next         = '0;
            digits_ended_next = 1'b0;
            trail_ok_next     = 1'b0;
        end

        phase_next = phase_mid;
        field_next = field_mid;
        if (in_last) begin
            phase_next        = arhp_pkg::PH_MAGIC;
            field_next        = '0;
            name_next         = '0;
            ncount_next       = '0;
            name_ended_next   = 1'b0;
            size_next         = '0;
            digits_ended_next = 1'b0;
            trail_ok_next     = 1'b0;
            remain_next       = '0;
            pad_next          = 1'b0;
            offset_next       = '0;
        end
    end

    always_comb begin
        step_hit    = magic_bad || trailer_step;
        step_status = magic_bad ? arhp_pkg::ST_BAD_MAGIC :
                      (trailer_good ? arhp_pkg::ST_OK : arhp_pkg::ST_BAD_TRAILER);
        end_hit     = in_last && (phase_mid != arhp_pkg::PH_HALT);
        end_status  = (phase_mid == arhp_pkg::PH_HEADER && field_mid == '0) ?
                      arhp_pkg::ST_END : arhp_pkg::ST_TRUNC;

        res_step        = '0;
        res_step.status = step_status;
        res_step.last   = !end_hit;
        if (step_status == arhp_pkg::ST_OK) begin
            res_step.name_low    = name_reg[0];
            res_step.name_high   = name_reg[1];
            res_step.name_length = ncount_reg;
            res_step.member_size = size_reg;
            res_step.data_offset = data_offset;
        end

        res_end        = '0;
        res_end.status = end_status;
        res_end.last   = 1'b1;

        step = '0;
        if (in_valid) begin
            priority if (step_hit && end_hit) begin
                step.count  = 2'd2;
                step.first  = res_step;
                step.second = res_end;
            end else if (step_hit) begin
                step.count = 2'd1;
                step.first = res_step;
            end else if (end_hit) begin
                step.count = 2'd1;
                step.first = res_end;
            end else begin
                step.count = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= arhp_pkg::PH_MAGIC;
            field_reg        <= '0;
            name_reg         <= '0;
            ncount_reg       <= '0;
            name_ended_reg   <= 1'b0;
            size_reg         <= '0;
            digits_ended_reg <= 1'b0;
            trail_ok_reg     <= 1'b0;
            remain_reg       <= '0;
            pad_reg          <= 1'b0;
            offset_reg       <= '0;
        end else if (in_valid) begin
            phase_reg        <= phase_next;
            field_reg        <= field_next;
            name_reg         <= name_next;
            ncount_reg       <= ncount_next;
            name_ended_reg   <= name_ended_next;
            size_reg         <= size_next;
            digits_ended_reg <= digits_ended_next;
            trail_ok_reg     <= trail_ok_next;
            remain_reg       <= remain_next;
            pad_reg          <= pad_next;
            offset_reg       <= offset_next;
        end
    end

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && phase_reg == arhp_pkg::PH_HALT && !in_last |-> step.count == 2'd0)
        else $error("halted parser produced a result");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_last |=> phase_reg == arhp_pkg::PH_MAGIC && offset_reg == '0)
        else $error("parser did not restart after final byte");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        step.count == 2'd2 |-> step.first.status == arhp_pkg::ST_OK &&
                               !step.first.last && step.second.last)
        else $error("two results must be a header followed by an end report");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step.count != 2'd3)
        else $error("more than two results for one item");

endmodule

/* rtl/core/ar_archive_header_parser.sv */
// Channel  | Valid/Ready         | Data                       | Marker
// input    | s_tvalid / s_tready | s_tdata: byte_value        | s_tlast: last_byte
// result   | m_tvalid / m_tready | m_tdata: header fields     | m_tuser: status, m_tlast
//
// One byte is taken per cycle while s_tready is high; the parser updates its state in the cycle of acceptance.
// A byte yields zero, one or two results, written into a four-entry result queue.
// s_tready is high while the queue holds two entries or fewer, so input keeps flowing
// while a result waits on m_tready; results leave at one per cycle while m_tready is high.
// aresetn is synchronous and active low; it empties the queue and restarts at the magic.
module ar_archive_header_parser #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // [63:0] name_low, [127:64] name_high,
                                    // [132:128] name_length, [166:133] member_size,
                                    // [198:167] data_offset, [199] zero
    output logic [2:0]   m_tuser,   // [2:0] status
    output logic         m_tlast
);

    arhp_pkg::step_t                 step;
    arhp_pkg::result_t               q_mem [arhp_pkg::QUEUE_DEPTH];
    arhp_pkg::result_t               head;
    logic [arhp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [arhp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [arhp_pkg::QCOUNT_W-1:0]   count_reg, count_next;
    logic                            s_accept;
    logic                            m_accept;

    assign s_tready = (count_reg <= arhp_pkg::QCOUNT_W'(arhp_pkg::QUEUE_DEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    arhp_parser #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .step    (step)
    );

    always_comb begin
        wr_ptr_next = wr_ptr_reg + arhp_pkg::QPTR_W'(step.count);
        rd_ptr_next = rd_ptr_reg + arhp_pkg::QPTR_W'(m_accept);
        count_next  = count_reg + arhp_pkg::QCOUNT_W'(step.count) -
                      arhp_pkg::QCOUNT_W'(m_accept);
    end

    always_ff @(posedge aclk) begin
        if (step.count != 2'd0) begin
            q_mem[wr_ptr_reg] <= step.first;
        end
        if (step.count == 2'd2) begin
            q_mem[wr_ptr_reg + 1'b1] <= step.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head    = q_mem[rd_ptr_reg];
    assign m_tdata = {1'b0, head.data_offset, head.member_size, head.name_length,
                      head.name_high, head.name_low};
    assign m_tuser = head.status;
    assign m_tlast = head.last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= arhp_pkg::QCOUNT_W'(arhp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        step.count != 2'd0 |-> s_accept)
        else $error("result produced without an accepted item");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && step.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop after a pop");

endmodule

/* tb/tb_ar_archive_header_parser.sv */
module tb_ar_archive_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DIR_ROWS     = 20;

    localparam logic [63:0] AR_MAGIC = "!<arch>\n";

    typedef struct packed {
        logic [7:0]        b;
        logic              lst;
        logic              pinned;
        arhp_pkg::status_t st;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    // predictor state
    arhp_pkg::phase_t                ph;
    logic [arhp_pkg::FIELD_W-1:0]    fidx;
    logic [63:0]                     nm_lo;
    logic [63:0]                     nm_hi;
    logic [arhp_pkg::NCOUNT_W-1:0]   ncount;
    logic                            nended;
    logic [arhp_pkg::SIZE_W-1:0]     size_acc;
    logic                            dig_ended;
    logic                            trl_ok;
    logic [arhp_pkg::SIZE_W-1:0]     pay_rem;
    logic                            pad_pend;
    logic [arhp_pkg::DOFF_W-1:0]     arc_off;

    arhp_pkg::result_t expected_hdrs[$];
    logic [7:0]        arc[$];

    logic              pin_flag;
    arhp_pkg::status_t pin_status;
    logic              hold_req;
    logic              tx_burst;
    logic              rx_burst;

    int errors;
    int items_in;
    int live_bytes;
    int results_checked;
    int ok_results;
    int input_stalls;
    int archives;
    int cycle_count;
    int exp_mark;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h21, 1'b1, 1'b1, arhp_pkg::ST_TRUNC},
        '{8'h00, 1'b0, 1'b1, arhp_pkg::ST_BAD_MAGIC},
        '{8'hFF, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h5A, 1'b1, 1'b0, arhp_pkg::ST_OK},
        '{8'h21, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h3C, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h61, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h72, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h63, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h68, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h3E, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h0A, 1'b1, 1'b1, arhp_pkg::ST_END},
        '{8'h21, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h3C, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h58, 1'b0, 1'b1, arhp_pkg::ST_BAD_MAGIC},
        '{8'hFF, 1'b1, 1'b0, arhp_pkg::ST_OK},
        '{8'hFF, 1'b1, 1'b1, arhp_pkg::ST_BAD_MAGIC},
        '{8'h21, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h3C, 1'b0, 1'b0, arhp_pkg::ST_OK},
        '{8'h61, 1'b1, 1'b1, arhp_pkg::ST_TRUNC}
    };

    ar_archive_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] magic_char(input int i);
        return AR_MAGIC[63 - 8*i -: 8];
    endfunction

    function automatic void open_header();
        ph        = arhp_pkg::PH_HEADER;
        fidx      = '0;
        nm_lo     = '0;
        nm_hi     = '0;
        ncount    = '0;
        nended    = 1'b0;
        size_acc  = '0;
        dig_ended = 1'b0;
        trl_ok    = 1'b0;
    endfunction

    function automatic void restart_archive();
        open_header();
        ph       = arhp_pkg::PH_MAGIC;
        pay_rem  = '0;
        pad_pend = 1'b0;
        arc_off  = '0;
    endfunction

    function automatic arhp_pkg::result_t header_result(input arhp_pkg::status_t st,
                                                       input logic full);
        arhp_pkg::result_t r;
        r = '0;
        r.status = st;
        if (full) begin
            r.name_low    = nm_lo;
            r.name_high   = nm_hi;
            r.name_length = ncount;
            r.member_size = size_acc;
            r.data_offset = arc_off;
        end
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic lst);
        arhp_pkg::result_t r [2];
        int                n;
        n = 0;
        if (ph != arhp_pkg::PH_HALT) live_bytes++;
        if (arc_off != '1) arc_off++;
        case (ph)
            arhp_pkg::PH_MAGIC: begin
                if (b != magic_char(int'(fidx[2:0]))) begin
                    r[n] = header_result(arhp_pkg::ST_BAD_MAGIC, 1'b0);
                    n++;
                    ph = arhp_pkg::PH_HALT;
                end else if (fidx == arhp_pkg::MAGIC_LAST) begin
                    open_header();
                end else begin
                    fidx++;
                end
            end
            arhp_pkg::PH_HEADER: begin
                if (fidx < arhp_pkg::HDR_NAME_END) begin
                    if (!nended) begin
                        if (b == arhp_pkg::CH_SLASH || b == arhp_pkg::CH_SPACE ||
                            b == arhp_pkg::CH_NUL) begin
                            nended = 1'b1;
                        end else if (ncount < arhp_pkg::NAME_FULL) begin
                            if (!ncount[3]) nm_lo[8*ncount[2:0] +: 8] = b;
                            else nm_hi[8*ncount[2:0] +: 8] = b;
                            ncount++;
                        end
                    end
                end else if (fidx >= arhp_pkg::HDR_SIZE_FIRST &&
                             fidx < arhp_pkg::HDR_TRAILER0) begin
                    if (!dig_ended) begin
                        if (b >= arhp_pkg::CH_ZERO && b <= arhp_pkg::CH_NINE) begin
                            size_acc = size_acc * 10 + (b - arhp_pkg::CH_ZERO);
                        end else begin
                            dig_ended = 1'b1;
                        end
                    end
                end else if (fidx == arhp_pkg::HDR_TRAILER0) begin
                    trl_ok = (b == arhp_pkg::CH_GRAVE);
                end
                if (fidx >= arhp_pkg::HDR_TRAILER1) begin
                    if (trl_ok && b == arhp_pkg::CH_LF) begin
                        r[n] = header_result(arhp_pkg::ST_OK, 1'b1);
                        n++;
                        pay_rem  = size_acc;
                        pad_pend = size_acc[0];
                        if (pay_rem != 0) begin
                            ph   = arhp_pkg::PH_PAYLOAD;
                            fidx = '0;
                        end else begin
                            open_header();
                        end
                    end else begin
                        r[n] = header_result(arhp_pkg::ST_BAD_TRAILER, 1'b0);
                        n++;
                        ph = arhp_pkg::PH_HALT;
                    end
                end else begin
                    fidx++;
                end
            end
            arhp_pkg::PH_PAYLOAD: begin
                if (pay_rem != 0) pay_rem--;
                if (pay_rem == 0) begin
                    if (pad_pend) begin
                        ph   = arhp_pkg::PH_PAD;
                        fidx = '0;
                    end else begin
                        open_header();
                    end
                end
            end
            arhp_pkg::PH_PAD: begin
                pad_pend = 1'b0;
                open_header();
            end
            default: begin
                ph = arhp_pkg::PH_HALT;
            end
        endcase
        if (lst) begin
            if (ph != arhp_pkg::PH_HALT) begin
                r[n] = header_result((ph == arhp_pkg::PH_HEADER && fidx == 0) ?
                                     arhp_pkg::ST_END : arhp_pkg::ST_TRUNC, 1'b0);
                n++;
            end
            restart_archive();
        end
        if (n > 0) r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_hdrs.push_back(r[i]);
    endtask

    task automatic cmp_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        arhp_pkg::result_t want;
        results_checked++;
        if (expected_hdrs.size() == 0) begin
            $error("unexpected result: status %0d", m_tuser);
            errors++;
        end else begin
            want = expected_hdrs.pop_front();
            if (want.status == arhp_pkg::ST_OK) ok_results++;
            cmp_field("status", 64'(want.status), 64'(m_tuser));
            cmp_field("name_low", want.name_low, m_tdata[63:0]);
            cmp_field("name_high", want.name_high, m_tdata[127:64]);
            cmp_field("name_length", 64'(want.name_length), 64'(m_tdata[132:128]));
            cmp_field("member_size", 64'(want.member_size), 64'(m_tdata[166:133]));
            cmp_field("data_offset", 64'(want.data_offset), 64'(m_tdata[198:167]));
            cmp_field("last_result", 64'(want.last), 64'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                items_in++;
                exp_mark = expected_hdrs.size();
                parse_byte(s_tdata, s_tlast);
                if (pin_flag) begin
                    while (expected_hdrs.size() > exp_mark) void'(expected_hdrs.pop_back());
                    expected_hdrs.push_back(header_result(pin_status, 1'b0));
                    expected_hdrs[expected_hdrs.size()-1].last = 1'b1;
                end
            end else if (s_tvalid) begin
                input_stalls++;
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic pin,
                             input arhp_pkg::status_t st);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   = 1'b1;
        s_tdata    = b;
        s_tlast    = lst;
        pin_flag   = pin;
        pin_status = st;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic add_member(output logic huge);
        int         nl;
        int         nd;
        int         c;
        int         v;
        int         dig [10];
        logic [arhp_pkg::SIZE_W-1:0] sz;
        huge = 1'b0;
        c  = $urandom_range(0, 7);
        nl = (c == 0) ? 0 : (c < 3) ? arhp_pkg::NAME_BYTES :
             $urandom_range(1, arhp_pkg::NAME_BYTES - 1);
        for (int i = 0; i < arhp_pkg::NAME_BYTES; i++) begin
            if (i < nl) begin
                do c = $urandom_range(1, 255);
                while (c == arhp_pkg::CH_SPACE || c == arhp_pkg::CH_SLASH);
                arc.push_back(8'(c));
            end else if (i == nl) begin
                case ($urandom_range(0, 2))
                    0: arc.push_back(arhp_pkg::CH_SLASH);
                    1: arc.push_back(arhp_pkg::CH_SPACE);
                    default: arc.push_back(arhp_pkg::CH_NUL);
                endcase
            end else begin
                arc.push_back(8'($urandom_range(0, 255)));
            end
        end
        repeat (32) arc.push_back(8'($urandom_range(0, 255)));

        c = $urandom_range(0, 9);
        if (c == 0) begin
            nd = 10;
            for (int i = 0; i < 10; i++) dig[i] = $urandom_range(0, 2) == 0 ? 9 : $urandom_range(0, 9);
        end else if (c == 1) begin
            nd = 0;
        end else begin
            v  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            nd = (v >= 10) ? 2 : 1;
            if ($urandom_range(0, 3) == 0) nd = $urandom_range(nd, 10);
            for (int i = nd - 1; i >= 0; i--) begin
                dig[i] = v % 10;
                v      = v / 10;
            end
        end
        sz = '0;
        for (int i = 0; i < 10; i++) begin
            if (i < nd) begin
                sz = sz * 10 + dig[i];
                arc.push_back(arhp_pkg::CH_ZERO + 8'(dig[i]));
            end else if (i == nd) begin
                if ($urandom_range(0, 1)) begin
                    arc.push_back(arhp_pkg::CH_SPACE);
                end else begin
                    do c = $urandom_range(0, 255);
                    while (c >= arhp_pkg::CH_ZERO && c <= arhp_pkg::CH_NINE);
                    arc.push_back(8'(c));
                end
            end else begin
                arc.push_back(8'($urandom_range(0, 255)));
            end
        end

        arc.push_back(arhp_pkg::CH_GRAVE);
        arc.push_back(arhp_pkg::CH_LF);
        c = $urandom_range(0, 11);
        if (c == 0) arc[arc.size()-2] = 8'($urandom_range(0, 255));
        if (c == 1) arc[arc.size()-1] = 8'($urandom_range(0, 255));

        if (sz > 64) begin
            huge = 1'b1;
            repeat ($urandom_range(0, 5)) arc.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (int'(sz)) arc.push_back(8'($urandom_range(0, 255)));
            if (sz[0]) arc.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic make_archive();
        int   kind;
        int   members;
        int   cut;
        logic open_end;
        arc.delete();
        open_end = 1'b0;
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6)) arc.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) arc[0] = magic_char(0);
        end else begin
            for (int i = 0; i < 8; i++) arc.push_back(magic_char(i));
            if (kind == 1) arc[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
            members = $urandom_range(0, 3);
            for (int m = 0; m < members && !open_end; m++) add_member(open_end);
            case ($urandom_range(0, 5))
                0: cut = 1;
                1: cut = $urandom_range(1, arc.size() - 1);
                default: cut = 0;
            endcase
            repeat (cut) void'(arc.pop_back());
        end
    endtask

    initial begin
        int stall;
        m_tready = 1'b0;
        rx_burst = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end
            if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        pin_flag        = 1'b0;
        pin_status      = arhp_pkg::ST_OK;
        hold_req        = 1'b0;
        tx_burst        = 1'b0;
        errors          = 0;
        items_in        = 0;
        live_bytes      = 0;
        results_checked = 0;
        ok_results      = 0;
        input_stalls    = 0;
        archives        = 0;
        cycle_count     = 0;
        restart_archive();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].pinned, dir_rows[i].st);
        end

        // back up the result queue until the input stalls
        hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (12) send_byte(arhp_pkg::CH_NUL, 1'b1, 1'b1, arhp_pkg::ST_BAD_MAGIC);

        while (items_in < RANDOM_ITEMS) begin
            make_archive();
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < arc.size(); i++) begin
                send_byte(arc[i], i == arc.size() - 1, 1'b0, arhp_pkg::ST_OK);
            end
            archives++;
        end
        s_tvalid = 1'b0;

        while (expected_hdrs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d archives streamed, %0d items in, %0d live bytes, %0d input stall cycles",
                 archives, items_in, live_bytes, input_stalls);
        $display("%0d results compared, %0d of them member headers", results_checked,
                 ok_results);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/arhp_pkg.sv
rtl/core/arhp_parser.sv
rtl/core/ar_archive_header_parser.sv
tb/tb_ar_archive_header_parser.sv
